// ===== rtl/core/minc_pkg.sv =====
// Package for the minicomputer execute unit: beat types, stop codes,
// opcode constants and flag helpers. No dependencies.
`timescale 1ns / 1ps

package minc_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned FlagW = 4;

  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [WordW-1:0] WordMin = 16'h8000;
  localparam logic [WordW-1:0] WordMax = 16'h7FFF;
  localparam logic [WordW-1:0] WordOnes = 16'hFFFF;

  // two-operand opcodes, bits 15:12
  localparam logic [3:0] OP2_MOV = 4'o01;
  localparam logic [3:0] OP2_CMP = 4'o02;
  localparam logic [3:0] OP2_BIT = 4'o03;
  localparam logic [3:0] OP2_BIC = 4'o04;
  localparam logic [3:0] OP2_BIS = 4'o05;
  localparam logic [3:0] OP2_ADD = 4'o06;
  localparam logic [3:0] OP2_SUB = 4'o16;

  // one-operand opcodes, bits 15:6
  localparam logic [9:0] OP1_CLR  = 10'o0050;
  localparam logic [9:0] OP1_COM  = 10'o0051;
  localparam logic [9:0] OP1_INC  = 10'o0052;
  localparam logic [9:0] OP1_DEC  = 10'o0053;
  localparam logic [9:0] OP1_NEG  = 10'o0054;
  localparam logic [9:0] OP1_ADC  = 10'o0055;
  localparam logic [9:0] OP1_TST  = 10'o0057;
  localparam logic [9:0] OP1_SWAB = 10'o0003;
  localparam logic [9:0] OP1_JMP  = 10'o0001;

  // branch opcodes, bits 15:8
  localparam logic [7:0] OPB_BR  = 8'o001;
  localparam logic [7:0] OPB_BNE = 8'o002;
  localparam logic [7:0] OPB_BEQ = 8'o003;
  localparam logic [7:0] OPB_BPL = 8'o200;
  localparam logic [7:0] OPB_BMI = 8'o201;

  typedef enum logic [1:0] {
    STOP_RUN     = 2'd0,
    STOP_HALT    = 2'd1,
    STOP_UNKNOWN = 2'd2,
    STOP_JMP_REG = 2'd3
  } stop_t;

  typedef struct packed {
    logic [WordW-1:0] instr_word;
    logic [WordW-1:0] src_value;
    logic [WordW-1:0] dst_value;
    logic [WordW-1:0] pc_value;
    logic [WordW-1:0] target_addr;
    logic             dst_is_register;
  } exec_in_t;

  typedef struct packed {
    logic [WordW-1:0] result_value;
    logic             write_back;
    logic [WordW-1:0] next_pc;
    logic [FlagW-1:0] flags_nzvc;
    logic [1:0]       stop_code;
  } exec_out_t;

  // {N, Z} of a word
  function automatic logic [1:0] nz_of(input logic [WordW-1:0] w);
    nz_of = {w[WordW-1], (w == '0)};
  endfunction

endpackage

// ===== rtl/core/minc_exec_alu.sv =====
// Decode and execute logic for one instruction beat, combinational.
// Depends on minc_pkg.
`timescale 1ns / 1ps

module minc_exec_alu (
  input  minc_pkg::exec_in_t              item,
  input  logic [minc_pkg::FlagW-1:0]      flags,
  output minc_pkg::exec_out_t             result
);

  logic [minc_pkg::WordW-1:0] src;
  logic [minc_pkg::WordW-1:0] dst;
  logic [minc_pkg::WordW-1:0] pc;
  logic [3:0]                 op2;
  logic [9:0]                 op1;
  logic [7:0]                 opb;

  logic [minc_pkg::WordW:0]   add_sum;
  logic [minc_pkg::WordW-1:0] cmp_diff;
  logic [minc_pkg::WordW-1:0] sub_diff;
  logic [minc_pkg::WordW-1:0] inc_val;
  logic [minc_pkg::WordW-1:0] dec_val;
  logic [minc_pkg::WordW-1:0] neg_val;
  logic [minc_pkg::WordW-1:0] adc_val;
  logic [minc_pkg::WordW-1:0] swab_val;
  logic [minc_pkg::WordW-1:0] br_target;
  logic [minc_pkg::WordW-1:0] and_val;
  logic [minc_pkg::WordW-1:0] bic_val;
  logic [minc_pkg::WordW-1:0] bis_val;
  logic                       c_in;

  logic [minc_pkg::WordW-1:0] res;
  logic                       wb;
  logic [minc_pkg::WordW-1:0] npc;
  logic [minc_pkg::FlagW-1:0] f;
  minc_pkg::stop_t            stop;
  logic                       take;

  assign src  = item.src_value;
  assign dst  = item.dst_value;
  assign pc   = item.pc_value;
  assign op2  = item.instr_word[15:12];
  assign op1  = item.instr_word[15:6];
  assign opb  = item.instr_word[15:8];
  assign c_in = flags[minc_pkg::FlagC];

  assign add_sum   = {1'b0, src} + {1'b0, dst};
  assign cmp_diff  = src - dst;
  assign sub_diff  = dst - src;
  assign inc_val   = dst + 16'd1;
  assign dec_val   = dst - 16'd1;
  assign neg_val   = ~dst + 16'd1;
  assign adc_val   = dst + {15'd0, c_in};
  assign swab_val  = {dst[7:0], dst[15:8]};
  assign and_val   = src & dst;
  assign bic_val   = dst & ~src;
  assign bis_val   = dst | src;
  assign br_target = pc + {{7{item.instr_word[7]}}, item.instr_word[7:0], 1'b0};

  always_comb begin
    res  = '0;
    wb   = 1'b0;
    npc  = pc;
    f    = flags;
    stop = minc_pkg::STOP_RUN;
    take = 1'b0;
    if (item.instr_word == '0) begin
      stop = minc_pkg::STOP_HALT;
    end else begin
      case (op2)
        minc_pkg::OP2_MOV: begin
          res = src;
          wb  = 1'b1;
          f   = {minc_pkg::nz_of(src), 1'b0, c_in};
        end
        minc_pkg::OP2_CMP: begin
          f = {minc_pkg::nz_of(cmp_diff),
               (src[15] ^ dst[15]) & (src[15] ^ cmp_diff[15]),
               (src < dst)};
        end
        minc_pkg::OP2_BIT: begin
          f = {minc_pkg::nz_of(and_val), 1'b0, c_in};
        end
        minc_pkg::OP2_BIC: begin
          res = bic_val;
          wb  = 1'b1;
          f   = {minc_pkg::nz_of(bic_val), 1'b0, c_in};
        end
        minc_pkg::OP2_BIS: begin
          res = bis_val;
          wb  = 1'b1;
          f   = {minc_pkg::nz_of(bis_val), 1'b0, c_in};
        end
        minc_pkg::OP2_ADD: begin
          res = add_sum[15:0];
          wb  = 1'b1;
          f   = {minc_pkg::nz_of(add_sum[15:0]),
                 ~(src[15] ^ dst[15]) & (src[15] ^ add_sum[15]),
                 add_sum[16]};
        end
        minc_pkg::OP2_SUB: begin
          res = sub_diff;
          wb  = 1'b1;
          f   = {minc_pkg::nz_of(sub_diff),
                 (dst[15] ^ src[15]) & (dst[15] ^ sub_diff[15]),
                 (dst < src)};
        end
        default: begin
          case (op1)
            minc_pkg::OP1_CLR: begin
              res = '0;
              wb  = 1'b1;
              f   = 4'b0100;
            end
            minc_pkg::OP1_COM: begin
              res = ~dst;
              wb  = 1'b1;
              f   = {minc_pkg::nz_of(~dst), 1'b0, 1'b1};
            end
            minc_pkg::OP1_INC: begin
              res = inc_val;
              wb  = 1'b1;
              f   = {minc_pkg::nz_of(inc_val), (dst == minc_pkg::WordMax), c_in};
            end
            minc_pkg::OP1_DEC: begin
              res = dec_val;
              wb  = 1'b1;
              f   = {minc_pkg::nz_of(dec_val), (dst == minc_pkg::WordMin), c_in};
            end
            minc_pkg::OP1_NEG: begin
              res = neg_val;
              wb  = 1'b1;
              f   = {minc_pkg::nz_of(neg_val), (neg_val == minc_pkg::WordMin),
                     (neg_val != '0)};
            end
            minc_pkg::OP1_ADC: begin
              res = adc_val;
              wb  = 1'b1;
              f   = {minc_pkg::nz_of(adc_val),
                     (dst == minc_pkg::WordMax) & c_in,
                     (dst == minc_pkg::WordOnes) & c_in};
            end
            minc_pkg::OP1_TST: begin
              f = {minc_pkg::nz_of(dst), 2'b00};
            end
            minc_pkg::OP1_SWAB: begin
              res = swab_val;
              wb  = 1'b1;
              f   = {swab_val[7], (swab_val[7:0] == 8'd0), 2'b00};
            end
            minc_pkg::OP1_JMP: begin
              if (item.dst_is_register) begin
                stop = minc_pkg::STOP_JMP_REG;
              end else begin
                npc = item.target_addr;
              end
            end
            default: begin
              case (opb)
                minc_pkg::OPB_BR:  take = 1'b1;
                minc_pkg::OPB_BNE: take = ~flags[minc_pkg::FlagZ];
                minc_pkg::OPB_BEQ: take = flags[minc_pkg::FlagZ];
                minc_pkg::OPB_BPL: take = ~flags[minc_pkg::FlagN];
                minc_pkg::OPB_BMI: take = flags[minc_pkg::FlagN];
                default:           stop = minc_pkg::STOP_UNKNOWN;
              endcase
              if (take) begin
                npc = br_target;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    result.result_value = res;
    result.write_back   = wb;
    result.next_pc      = npc;
    result.flags_nzvc   = f;
    result.stop_code    = stop;
  end

endmodule

// ===== rtl/core/minicomputer_instruction_execute_unit.sv =====
// Top level of the minicomputer execute unit: input register, execute
// logic, NZVC flag register and output register. Depends on minc_pkg, minc_exec_alu.
`timescale 1ns / 1ps

// Usage:
//   item/item_valid/item_ready carry one instruction beat with its fetched
//   operands, PC and destination address. result/result_valid/result_ready
//   carry the result word, write-back mark, next PC, flags and stop code.
//   Path: an accepted beat goes through the input register, then the output register.
//   Throughput: one beat per cycle unless the output stalls; the flag register
//   is read by the execute logic and written as the beat moves into the output
//   register, so the next instruction sees it with no gap.
//   Stall: while result_valid is high and result_ready low, the output
//   register holds; the input register still takes one beat, and item_ready
//   drops only when both registers are full.
//   Reset: rst empties both registers and clears all flags.

module minicomputer_instruction_execute_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  minc_pkg::exec_in_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output minc_pkg::exec_out_t  result
);

  logic                       stage_valid;
  minc_pkg::exec_in_t         stage;
  logic [minc_pkg::FlagW-1:0] flags;
  minc_pkg::exec_out_t        exec_out;
  logic                       advance;

  assign advance    = ~result_valid | result_ready;
  assign item_ready = ~stage_valid | advance;

  minc_exec_alu u_alu (
    .item   (stage),
    .flags  (flags),
    .result (exec_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      flags        <= '0;
    end else if (advance) begin
      result_valid <= stage_valid;
      if (stage_valid) begin
        flags <= exec_out.flags_nzvc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      result <= exec_out;
    end
  end

`ifndef SYNTHESIS
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && stage_valid) |=> $stable(flags))
    else $error("flags changed without a beat moving to the output");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.flags_nzvc == flags))
    else $error("output flags differ from flag register");

  a_stop_no_wb: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.stop_code != minc_pkg::STOP_RUN) |-> !result.write_back)
    else $error("write-back asserted on a stopped instruction");
`endif

endmodule
